// ----- hdl/rrio_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared types, codes and default sizes for the round-robin scheduler with an
// I/O wait queue.
// ----------------------------------------------------------------------------
package rrio_pkg;

  // Default number of process slots across both queues.
  localparam int unsigned MaxProcsDefault = 16;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_QUANTUM_RELOAD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IO_WAIT_TICKS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_BURST   = 2'd2;

  // Register values after reset.
  localparam logic [7:0] QuantumReset = 8'd2;
  localparam logic [7:0] IoWaitReset  = 8'd5;
  localparam logic [7:0] SecondReset  = 8'd7;

  // Input commands.
  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Scheduler events reported with each result.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ROTATED  = 3'd1,
    EV_TO_WAIT  = 3'd2,
    EV_FINISHED = 3'd3,
    EV_REJECTED = 3'd4
  } rrio_event_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADMIT,
    ST_WAIT_UPD,
    ST_RUN_RD,
    ST_RUN_UPD,
    ST_HOLD
  } rrio_state_e;

  // Input transaction.
  typedef struct packed {
    logic        cmd;
    logic [15:0] proc_id;
    logic [7:0]  burst_len;
  } rrio_in_t;

  // Output transaction.
  typedef struct packed {
    logic        run_valid;
    logic [15:0] run_proc;
    logic        wait_valid;
    logic [15:0] wait_proc;
    rrio_event_e event_res;
    logic [15:0] served_count;
    logic        all_done;
  } rrio_out_t;

  // One run queue entry.
  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  burst;
    logic [7:0]  quant;
    logic        second;
  } rrio_run_t;

  // One wait queue entry.
  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  left;
  } rrio_wait_t;

endpackage

// ----- hdl/round_robin_with_io_wait.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler with I/O wait queue
// Tick-driven scheduler keeping a run FIFO and a single-server wait FIFO in
// two synchronous memories, updated by read, modify and write back.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid_i/stall_o | rrio_in_t (cmd, id, burst)
//  out     | output    | out_valid_o/stall_i| rrio_out_t (one per input)
//  cfg     | input     | cfg_valid_i/ready_o| register index and 8-bit data
//
// An admit passes through the admit state to the output register; a tick reads
// and updates the wait head, then reads the run head (after any rejoin write)
// and updates it. A result meeting a stalled, full output register waits in a
// hold state while the input stays stalled. Reset clears pointers, fill
// counts, the tick counter and the output valid flag, and loads the
// configuration defaults; the contents of empty entries are never used.
module round_robin_with_io_wait #(
  parameter int unsigned MAX_PROCS = rrio_pkg::MaxProcsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rrio_pkg::rrio_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rrio_pkg::rrio_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrio_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrio_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned FW = $clog2(MAX_PROCS + 1);

  // Advance a queue pointer with wrap at the slot count.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(MAX_PROCS - 1)) ? '0 : p + PW'(1);
  endfunction

  rrio_pkg::rrio_state_e state_q, state_d;

  logic [7:0] quantum_q, io_wait_q, second_q;

  logic [PW-1:0] run_head_q, run_head_d, run_tail_q, run_tail_d;
  logic [PW-1:0] wait_head_q, wait_head_d, wait_tail_q, wait_tail_d;
  logic [FW-1:0] run_fill_q, run_fill_d, wait_fill_q, wait_fill_d;
  logic [15:0]   tick_total_q, tick_total_d;

  rrio_pkg::rrio_in_t  in_q;
  rrio_pkg::rrio_out_t res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Memories and their registered read ports.
  rrio_pkg::rrio_run_t  run_mem [MAX_PROCS];
  rrio_pkg::rrio_wait_t wait_mem [MAX_PROCS];
  rrio_pkg::rrio_run_t  run_rd_q;
  rrio_pkg::rrio_wait_t wait_rd_q;

  logic                 run_we, wait_we;
  logic [PW-1:0]        run_wa, wait_wa;
  rrio_pkg::rrio_run_t  run_wd;
  rrio_pkg::rrio_wait_t wait_wd;

  logic        in_acc, out_acc, out_free, fin_step;
  logic [FW:0] fill_sum;
  logic [7:0]  wait_left, run_burst;

  assign in_stall_o  = (state_q != rrio_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign fill_sum  = {1'b0, run_fill_q} + {1'b0, wait_fill_q};
  assign wait_left = wait_rd_q.left - 8'd1;
  assign run_burst = run_rd_q.burst - 8'd1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrio_pkg::QuantumReset;
      io_wait_q <= rrio_pkg::IoWaitReset;
      second_q  <= rrio_pkg::SecondReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rrio_pkg::CFG_QUANTUM_RELOAD: quantum_q <= cfg_data_i;
        rrio_pkg::CFG_IO_WAIT_TICKS:  io_wait_q <= cfg_data_i;
        rrio_pkg::CFG_SECOND_BURST:   second_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memory write and read ports; reads follow the queue heads every cycle.
  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_wa] <= run_wd;
    end
    run_rd_q <= run_mem[run_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_wa] <= wait_wd;
    end
    wait_rd_q <= wait_mem[wait_head_q];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrio_pkg::ST_IDLE;
      run_head_q   <= '0;
      run_tail_q   <= '0;
      run_fill_q   <= '0;
      wait_head_q  <= '0;
      wait_tail_q  <= '0;
      wait_fill_q  <= '0;
      tick_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      run_head_q   <= run_head_d;
      run_tail_q   <= run_tail_d;
      run_fill_q   <= run_fill_d;
      wait_head_q  <= wait_head_d;
      wait_tail_q  <= wait_tail_d;
      wait_fill_q  <= wait_fill_d;
      tick_total_q <= tick_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  // Sequencer: next state, queue updates and memory writes.
  always_comb begin
    state_d      = state_q;
    run_head_d   = run_head_q;
    run_tail_d   = run_tail_q;
    run_fill_d   = run_fill_q;
    wait_head_d  = wait_head_q;
    wait_tail_d  = wait_tail_q;
    wait_fill_d  = wait_fill_q;
    tick_total_d = tick_total_q;
    res_d        = res_q;
    run_we       = 1'b0;
    run_wa       = run_tail_q;
    run_wd       = '{pid: in_q.proc_id, burst: in_q.burst_len, quant: quantum_q,
                     second: 1'b0};
    wait_we      = 1'b0;
    wait_wa      = wait_tail_q;
    wait_wd      = '{pid: run_rd_q.pid, left: io_wait_q};
    fin_step     = 1'b0;

    unique case (state_q)
      rrio_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = (in_data_i.cmd == rrio_pkg::CMD_TICK) ?
                    rrio_pkg::ST_WAIT_UPD : rrio_pkg::ST_ADMIT;
        end
      end

      // Admit: append to the run tail unless every slot is taken.
      rrio_pkg::ST_ADMIT: begin
        fin_step = 1'b1;
        if (fill_sum >= (FW + 1)'(MAX_PROCS)) begin
          res_d.event_res = rrio_pkg::EV_REJECTED;
        end else begin
          run_we     = 1'b1;
          run_tail_d = next_ptr(run_tail_q);
          run_fill_d = run_fill_q + FW'(1);
        end
      end

      // Tick the wait head; on expiry it rejoins the run tail.
      rrio_pkg::ST_WAIT_UPD: begin
        state_d = rrio_pkg::ST_RUN_RD;
        if (wait_fill_q != '0) begin
          res_d.wait_valid = 1'b1;
          res_d.wait_proc  = wait_rd_q.pid;
          if (wait_left == 8'd0) begin
            wait_head_d = next_ptr(wait_head_q);
            wait_fill_d = wait_fill_q - FW'(1);
            run_we      = 1'b1;
            run_wd      = '{pid: wait_rd_q.pid, burst: second_q, quant: quantum_q,
                            second: 1'b1};
            run_tail_d  = next_ptr(run_tail_q);
            run_fill_d  = run_fill_q + FW'(1);
          end else begin
            wait_we = 1'b1;
            wait_wa = wait_head_q;
            wait_wd = '{pid: wait_rd_q.pid, left: wait_left};
          end
        end
      end

      // The run head is read after any rejoin write has landed.
      rrio_pkg::ST_RUN_RD: begin
        state_d = rrio_pkg::ST_RUN_UPD;
      end

      // Serve the run head for one tick.
      rrio_pkg::ST_RUN_UPD: begin
        fin_step = 1'b1;
        if (run_fill_q != '0) begin
          res_d.run_valid = 1'b1;
          res_d.run_proc  = run_rd_q.pid;
          tick_total_d    = tick_total_q + 16'd1;
          if (run_burst == 8'd0 && run_rd_q.second) begin
            run_head_d      = next_ptr(run_head_q);
            run_fill_d      = run_fill_q - FW'(1);
            res_d.event_res = rrio_pkg::EV_FINISHED;
          end else if (run_burst == 8'd0) begin
            run_head_d      = next_ptr(run_head_q);
            run_fill_d      = run_fill_q - FW'(1);
            wait_we         = 1'b1;
            wait_tail_d     = next_ptr(wait_tail_q);
            wait_fill_d     = wait_fill_q + FW'(1);
            res_d.event_res = rrio_pkg::EV_TO_WAIT;
          end else if (run_rd_q.quant == 8'd0) begin
            // Rotate: pop the head and push it back at the tail.
            run_head_d      = next_ptr(run_head_q);
            run_we          = 1'b1;
            run_wd          = '{pid: run_rd_q.pid, burst: run_burst, quant: quantum_q,
                                second: run_rd_q.second};
            run_tail_d      = next_ptr(run_tail_q);
            res_d.event_res = rrio_pkg::EV_ROTATED;
          end else begin
            run_we = 1'b1;
            run_wa = run_head_q;
            run_wd = '{pid: run_rd_q.pid, burst: run_burst,
                       quant: run_rd_q.quant - 8'd1, second: run_rd_q.second};
          end
        end
      end

      rrio_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = rrio_pkg::ST_IDLE;
        end
      end

      default: state_d = rrio_pkg::ST_IDLE;
    endcase

    // Counters and completion flag as they stand after this transaction.
    if (fin_step) begin
      res_d.served_count = tick_total_d;
      res_d.all_done     = (run_fill_d == '0) && (wait_fill_d == '0);
      state_d            = out_free ? rrio_pkg::ST_IDLE : rrio_pkg::ST_HOLD;
    end
  end

  // Output register: loaded straight from the final step, or from the hold.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_acc;
    if (fin_step && out_free) begin
      out_d       = res_d;
      out_valid_d = 1'b1;
    end else if (state_q == rrio_pkg::ST_HOLD && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  // Checks on the queue bookkeeping and results.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_sum <= (FW + 1)'(MAX_PROCS))
    else $error("process count exceeds slot count");

  a_run_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_fill_q == '0) |-> (run_head_q == run_tail_q))
    else $error("run queue empty with unequal pointers");

  a_wait_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_fill_q == '0) |-> (wait_head_q == wait_tail_q))
    else $error("wait queue empty with unequal pointers");

  a_event_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_res == rrio_pkg::EV_ROTATED ||
                     out_data_o.event_res == rrio_pkg::EV_TO_WAIT ||
                     out_data_o.event_res == rrio_pkg::EV_FINISHED))
    |-> out_data_o.run_valid)
    else $error("run event reported without a served process");

endmodule
